// File: design/forward_warp_zbuffer_core_macros.svh
// assertion macros used by the forward warp z-buffer back module
`ifndef FORWARD_WARP_ZBUFFER_CORE_MACROS_SVH
`define FORWARD_WARP_ZBUFFER_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define FWZ_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FWZ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/fwz_pkg.sv
// shared types, constants and helpers of the forward warp z-buffer
package fwz_pkg;

   localparam int COORD_W   = 12;
   localparam int KEY_W     = 24;
   localparam int CSR_W     = 60;
   localparam int CSR_IDX_W = 3;

   // action codes
   localparam logic ACT_PROJECT = 1'b0;
   localparam logic ACT_READ    = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROT0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_K0    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_K1    = 3'd5;

   // register reset values
   localparam logic [53:0] ROT0_RST  = 54'd65536;
   localparam logic [53:0] ROT1_RST  = 54'd4294967296;
   localparam logic [53:0] ROT2_RST  = 54'd1125899906842624;
   localparam logic [59:0] TRANS_RST = 60'd0;
   localparam logic [53:0] K0_RST    = 54'd32;
   localparam logic [53:0] K1_RST    = 54'd8589934592;

   localparam logic [7:0]       PIX_EMPTY = 8'd255;
   localparam logic [7:0]       CNT_MAX   = 8'd255;
   localparam logic [KEY_W-1:0] KEY_MAX   = 24'hFFFFFF;

   typedef struct packed {
      logic              action;
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic signed [23:0] point_z;
      logic [7:0]        intensity;
      logic [8:0]        read_col;
      logic [8:0]        read_row;
   } req_type;

   typedef struct packed {
      logic       landed;
      logic [8:0] target_col;
      logic [8:0] target_row;
      logic       became_front;
      logic [7:0] pixel_value;
      logic [7:0] hit_count;
      logic       is_hole;
   } rsp_type;

   // classified transaction from front to back
   typedef struct packed {
      logic               action;
      logic               live;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [7:0]         intensity;
      logic [KEY_W-1:0]   key;
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0] depth;
      logic [7:0]       value;
      logic [7:0]       count;
   } pix_type;

   typedef enum logic [2:0] {
      F_IDLE, F_MUL, F_ACC, F_DSET, F_DIV, F_FIN, F_OUT
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR, B_IDLE, B_ADDR, B_READ, B_UPD
   } back_state_type;

   // signed 18-bit matrix entry j of a packed row
   function automatic logic signed [17:0] coef(input logic [53:0] r, input logic [1:0] j);
      logic signed [17:0] v;
      v = r[18*j +: 18];
      return v;
   endfunction

endpackage

// File: design/fwz_front.sv
// projection front: config registers, shared multiplier, divider, classification
module fwz_front import fwz_pkg::*; #(
   parameter int IMG_WIDTH  = 512,
   parameter int IMG_HEIGHT = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   input  logic                 hold,
   output logic                 cmd_vld,
   input  logic                 cmd_ready,
   output cmd_type              cmd_data
);

   localparam int MAX_DIM = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
   localparam int QW      = $clog2(MAX_DIM) + 1;
   localparam int STEP_W  = $clog2(QW);
   localparam int PROD_W  = 52;
   localparam int ACC_W   = 56;
   localparam int C_W     = 34;
   localparam int REM_W   = 58;

   logic [53:0] rot_ff [3];
   logic [53:0] kmat_ff [2];
   logic [59:0] trans_ff;

   front_state_type state_ff, state_in;
   logic [1:0]  row_ff, col_ff;
   logic        proj_ff;
   logic [STEP_W-1:0] step_ff;

   logic signed [23:0]     p_ff [3];
   logic [7:0]             int_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, un_ff, vn_ff;
   logic signed [C_W-1:0]    c_ff [3];
   logic [REM_W-1:0]       rem_u_ff, rem_v_ff;
   logic [QW-1:0]          q_u_ff, q_v_ff;
   logic                   ovf_u_ff, ovf_v_ff, neg_u_ff, neg_v_ff;
   cmd_type                cmd_ff;

   logic accept;
   logic signed [17:0]       mul_a;
   logic signed [C_W-1:0]    mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [19:0]       tr_sel;
   logic signed [C_W-1:0]    c_new;
   logic                     c_nonpos;
   logic [REM_W-1:0]         dd, trial, abs_u, abs_v, n_u, n_v;
   logic                     land_u, land_v, read_in;
   cmd_type                  cmd_read, cmd_fin;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]  <= ROT0_RST;
         rot_ff[1]  <= ROT1_RST;
         rot_ff[2]  <= ROT2_RST;
         trans_ff   <= TRANS_RST;
         kmat_ff[0] <= K0_RST;
         kmat_ff[1] <= K1_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT0:  rot_ff[0]  <= csr_wdata[53:0];
            CSR_ROT1:  rot_ff[1]  <= csr_wdata[53:0];
            CSR_ROT2:  rot_ff[2]  <= csr_wdata[53:0];
            CSR_TRANS: trans_ff   <= csr_wdata;
            CSR_K0:    kmat_ff[0] <= csr_wdata[53:0];
            CSR_K1:    kmat_ff[1] <= csr_wdata[53:0];
            default: ;
         endcase
      end
   end

   // multiplier operands: rotation pass or projection pass
   always_comb begin
      mul_a   = proj_ff ? coef(kmat_ff[row_ff[0]], col_ff) : coef(rot_ff[row_ff], col_ff);
      mul_b   = proj_ff ? c_ff[col_ff] : C_W'(p_ff[col_ff]);
      prod_in = mul_a * mul_b;
      acc_sum = acc_ff + ACC_W'(prod_ff);
      tr_sel  = trans_ff[20*row_ff +: 20];
      c_new   = C_W'(acc_sum >>> 12) + (C_W'(tr_sel) <<< 4);
      c_nonpos = c_new[C_W-1] || (c_new == '0);
   end

   // divider operands: round half away from zero as (2|n| + d) / 2d
   always_comb begin
      dd    = REM_W'({c_ff[2][32:0], 6'b0});
      trial = dd << step_ff;
      abs_u = REM_W'(un_ff[ACC_W-1] ? -un_ff : un_ff);
      abs_v = REM_W'(vn_ff[ACC_W-1] ? -vn_ff : vn_ff);
      n_u   = (abs_u << 1) + REM_W'({c_ff[2][32:0], 5'b0});
      n_v   = (abs_v << 1) + REM_W'({c_ff[2][32:0], 5'b0});
      land_u = !ovf_u_ff && (32'(q_u_ff) < IMG_WIDTH) && (!neg_u_ff || q_u_ff == '0);
      land_v = !ovf_v_ff && (32'(q_v_ff) < IMG_HEIGHT) && (!neg_v_ff || q_v_ff == '0);
   end

   // result transactions
   always_comb begin
      read_in = (32'(req_data.read_col) < IMG_WIDTH) && (32'(req_data.read_row) < IMG_HEIGHT);
      cmd_read           = '0;
      cmd_read.action    = ACT_READ;
      cmd_read.live      = read_in;
      cmd_read.col       = COORD_W'(req_data.read_col);
      cmd_read.row       = COORD_W'(req_data.read_row);
      cmd_fin            = '0;
      cmd_fin.action     = ACT_PROJECT;
      cmd_fin.live       = land_u && land_v;
      cmd_fin.col        = COORD_W'(q_u_ff);
      cmd_fin.row        = COORD_W'(q_v_ff);
      cmd_fin.intensity  = int_ff;
      cmd_fin.key        = (|c_ff[2][C_W-1:28]) ? KEY_MAX : c_ff[2][27:4];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) begin
            state_in = (req_data.action == ACT_READ) ? F_OUT : F_MUL;
         end
         F_MUL: state_in = F_ACC;
         F_ACC: begin
            if (col_ff != 2'd2) begin
               state_in = F_MUL;
            end else if (!proj_ff) begin
               state_in = (row_ff == 2'd2 && c_nonpos) ? F_OUT : F_MUL;
            end else begin
               state_in = (row_ff == 2'd0) ? F_MUL : F_DSET;
            end
         end
         F_DSET: state_in = F_DIV;
         F_DIV:  if (step_ff == '0) begin
            state_in = F_FIN;
         end
         F_FIN:  state_in = F_OUT;
         F_OUT:  if (cmd_ready) begin
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_full = (state_ff != F_IDLE) || hold;
      cmd_vld  = (state_ff == F_OUT);
      accept   = req_push && !req_full;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         proj_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == F_IDLE) begin
            row_ff  <= '0;
            col_ff  <= '0;
            proj_ff <= 1'b0;
         end else if (state_ff == F_ACC) begin
            if (col_ff != 2'd2) begin
               col_ff <= col_ff + 2'd1;
            end else begin
               col_ff <= '0;
               if (!proj_ff && row_ff == 2'd2) begin
                  row_ff  <= '0;
                  proj_ff <= 1'b1;
               end else begin
                  row_ff <= row_ff + 2'd1;
               end
            end
         end
         if (state_ff == F_DSET) begin
            step_ff <= STEP_W'(QW - 1);
         end else if (state_ff == F_DIV) begin
            step_ff <= step_ff - 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         F_IDLE: if (accept) begin
            p_ff[0] <= req_data.point_x;
            p_ff[1] <= req_data.point_y;
            p_ff[2] <= req_data.point_z;
            int_ff  <= req_data.intensity;
            acc_ff  <= '0;
            cmd_ff  <= cmd_read;
         end
         F_MUL: prod_ff <= prod_in;
         F_ACC: begin
            if (col_ff != 2'd2) begin
               acc_ff <= acc_sum;
            end else begin
               acc_ff <= '0;
               if (!proj_ff) begin
                  c_ff[row_ff] <= c_new;
                  cmd_ff <= '0;
               end else if (row_ff == 2'd0) begin
                  un_ff <= acc_sum;
               end else begin
                  vn_ff <= acc_sum;
               end
            end
         end
         F_DSET: begin
            rem_u_ff <= n_u;
            rem_v_ff <= n_v;
            ovf_u_ff <= n_u >= (dd << QW);
            ovf_v_ff <= n_v >= (dd << QW);
            neg_u_ff <= un_ff[ACC_W-1];
            neg_v_ff <= vn_ff[ACC_W-1];
            q_u_ff   <= '0;
            q_v_ff   <= '0;
         end
         F_DIV: begin
            if (rem_u_ff >= trial) begin
               rem_u_ff        <= rem_u_ff - trial;
               q_u_ff[step_ff] <= 1'b1;
            end
            if (rem_v_ff >= trial) begin
               rem_v_ff        <= rem_v_ff - trial;
               q_v_ff[step_ff] <= 1'b1;
            end
         end
         F_FIN: cmd_ff <= cmd_fin;
         default: ;
      endcase
   end

   assign cmd_data = cmd_ff;

endmodule

// File: design/fwz_cmd_fifo.sv
// two-entry queue between projection front and z-buffer back
module fwz_cmd_fifo import fwz_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  cmd_type din,
   input  logic    pop,
   output logic    empty,
   output cmd_type dout
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: design/fwz_back.sv
// z-buffer back: pixel memory, clearing pass, read-modify-write, result register
`include "forward_warp_zbuffer_core_macros.svh"
module fwz_back import fwz_pkg::*; #(
   parameter int IMG_WIDTH  = 512,
   parameter int IMG_HEIGHT = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_vld,
   output logic    cmd_pop,
   input  cmd_type cmd_data,
   output logic    clearing,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int NPIX = IMG_WIDTH * IMG_HEIGHT;
   localparam int AW   = $clog2(NPIX);

   back_state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff;
   logic           out_vld_ff;

   pix_type        mem [NPIX];
   cmd_type        cmd_ff;
   logic [AW-1:0]  addr_ff;
   pix_type        rd_ff;
   rsp_type        rsp_ff;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   pix_type        mem_wdata, pix_clr, pix_new;
   logic           front;
   rsp_type        rsp_in;

   // z test and saturating count
   always_comb begin
      front = (rd_ff.count == '0) || (cmd_ff.key < rd_ff.depth);
      pix_new.depth = front ? cmd_ff.key : rd_ff.depth;
      pix_new.value = front ? cmd_ff.intensity : rd_ff.value;
      pix_new.count = (rd_ff.count == CNT_MAX) ? CNT_MAX : rd_ff.count + 8'd1;
      pix_clr       = '{depth: '0, value: PIX_EMPTY, count: '0};
   end

   // result of the current transaction
   always_comb begin
      rsp_in = '0;
      if (cmd_ff.action == ACT_READ) begin
         rsp_in.target_col = cmd_ff.col[8:0];
         rsp_in.target_row = cmd_ff.row[8:0];
         if (cmd_ff.live) begin
            rsp_in.pixel_value = rd_ff.value;
            rsp_in.hit_count   = rd_ff.count;
            rsp_in.is_hole     = (rd_ff.count == '0);
         end else begin
            rsp_in.pixel_value = PIX_EMPTY;
            rsp_in.is_hole     = 1'b1;
         end
      end else if (cmd_ff.live) begin
         rsp_in.landed       = 1'b1;
         rsp_in.target_col   = cmd_ff.col[8:0];
         rsp_in.target_row   = cmd_ff.row[8:0];
         rsp_in.became_front = front;
         rsp_in.pixel_value  = pix_new.value;
         rsp_in.hit_count    = pix_new.count;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: if (clr_ff == AW'(NPIX - 1)) begin
            state_in = B_IDLE;
         end
         B_IDLE: if (cmd_vld && !out_vld_ff) begin
            state_in = B_ADDR;
         end
         B_ADDR: state_in = B_READ;
         B_READ: state_in = B_UPD;
         B_UPD:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      clearing  = (state_ff == B_CLEAR);
      cmd_pop   = (state_ff == B_IDLE) && cmd_vld && !out_vld_ff;
      mem_we    = clearing || ((state_ff == B_UPD) && cmd_ff.live &&
                  (cmd_ff.action == ACT_PROJECT));
      mem_waddr = clearing ? clr_ff : addr_ff;
      mem_wdata = clearing ? pix_clr : pix_new;
      rsp_empty = !out_vld_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_CLEAR;
         clr_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == B_UPD) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // transaction, address and result registers
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (state_ff == B_ADDR) begin
         addr_ff <= AW'(cmd_ff.row * IMG_WIDTH) + AW'(cmd_ff.col);
      end
      if (state_ff == B_UPD) begin
         rsp_ff <= rsp_in;
      end
   end

   // pixel memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[addr_ff];
   end

   assign rsp_data = rsp_ff;

   `FWZ_ASSERT_IMP(a_upd_slot_free, state_ff == B_UPD, !out_vld_ff, "result register busy on update")
   `FWZ_ASSERT_NEXT(a_upd_loads_rsp, state_ff == B_UPD, out_vld_ff, "update did not load a result")
   `FWZ_ASSERT_IMP(a_no_pop_in_clear, state_ff == B_CLEAR, !cmd_pop, "transaction taken while clearing")

endmodule

// File: design/forward_warp_zbuffer_core.sv
// top level of the forward warp z-buffer
// Forward warp z-buffer. Project transactions rotate, translate and project a
// point and update the target pixel (nearest depth wins, hit count saturates);
// read transactions return one pixel. After reset a clearing pass walks the
// whole pixel memory with req_full high. A project transaction runs through
// fifteen multiply-accumulate steps on one shared multiplier in the front (a
// point with nonpositive depth stops after the rotation pass), then a restoring
// divider one quotient bit per cycle. A read goes from idle straight to the
// output state of the front. The back runs each transaction through its address,
// read and update states for the memory read-modify-write; a two-entry queue
// and the result register let front and back stall independently.
module forward_warp_zbuffer_core import fwz_pkg::*; #(
   parameter int IMG_WIDTH  = 512,
   parameter int IMG_HEIGHT = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data
);

   logic    clearing;
   logic    f_vld, q_full, q_empty, q_pop;
   cmd_type f_cmd, q_cmd;

   fwz_front #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)) u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .hold(clearing),
      .cmd_vld(f_vld), .cmd_ready(!q_full), .cmd_data(f_cmd)
   );

   fwz_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(f_vld), .full(q_full), .din(f_cmd),
      .pop(q_pop), .empty(q_empty), .dout(q_cmd)
   );

   fwz_back #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)) u_back (
      .clock(clock), .reset(reset),
      .cmd_vld(!q_empty), .cmd_pop(q_pop), .cmd_data(q_cmd),
      .clearing(clearing),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule

// File: tb/tb_top.sv
// testbench for the forward warp z-buffer core: random and directed transactions, scoreboard check
module tb_top;
   import fwz_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic                 req_push;
   logic                 req_full;
   req_type              req_data;
   logic                 rsp_empty;
   logic                 rsp_pop;
   rsp_type              rsp_data;

   forward_warp_zbuffer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // shadow copy of the registers
   logic [53:0] rot_mirror [3];
   logic [59:0] trans_mirror;
   logic [53:0] cam_mirror [2];

   // shadow pixel memory, sparse
   logic [23:0] depth_mem [int];
   logic [7:0]  value_mem [int];
   logic [7:0]  count_mem [int];

   req_type point_queue [$];
   rsp_type predicted_pixels [$];
   int      err_count;

   // clock generator
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // append one pending transaction for the driver
   function automatic void add_item(req_type r);
      point_queue = {point_queue, r};
   endfunction

   function automatic longint entry18(logic [53:0] r, int j);
      logic signed [17:0] v;
      v = r[18*j +: 18];
      return v;
   endfunction

   function automatic longint entry20(logic [59:0] r, int j);
      logic signed [19:0] v;
      v = r[20*j +: 20];
      return v;
   endfunction

   function automatic longint div_round(longint num, longint den);
      longint a;
      longint q;
      a = (num < 0) ? -num : num;
      q = (2 * a + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   // expected result of one transaction; updates the shadow pixel memory
   function automatic rsp_type warp_pixel(req_type r);
      rsp_type     o;
      longint      p [3];
      longint      c [3];
      longint      acc;
      longint      un;
      longint      vn;
      longint      tx;
      longint      ty;
      int          addr;
      logic [23:0] key;
      logic [7:0]  cnt;
      bit          front;
      o = '0;
      if (r.action == ACT_READ) begin
         addr = int'({r.read_row, r.read_col});
         o.target_col = r.read_col;
         o.target_row = r.read_row;
         cnt = count_mem.exists(addr) ? count_mem[addr] : 8'd0;
         o.pixel_value = value_mem.exists(addr) ? value_mem[addr] : PIX_EMPTY;
         o.hit_count = cnt;
         o.is_hole = (cnt == 0);
         return o;
      end
      p[0] = r.point_x;
      p[1] = r.point_y;
      p[2] = r.point_z;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += entry18(rot_mirror[i], j) * p[j];
         c[i] = (acc >>> 12) + entry20(trans_mirror, i) * 16;
      end
      if (c[2] <= 0) return o;
      un = 0;
      vn = 0;
      for (int j = 0; j < 3; j++) begin
         un += entry18(cam_mirror[0], j) * c[j];
         vn += entry18(cam_mirror[1], j) * c[j];
      end
      tx = div_round(un, c[2] * 32);
      ty = div_round(vn, c[2] * 32);
      if (tx < 0 || tx >= 512 || ty < 0 || ty >= 512) return o;
      key = ((c[2] >>> 4) > 64'hFFFFFF) ? KEY_MAX : 24'(c[2] >>> 4);
      addr = int'(ty) * 512 + int'(tx);
      cnt = count_mem.exists(addr) ? count_mem[addr] : 8'd0;
      front = (cnt == 0) || (key < depth_mem[addr]);
      if (front) begin
         depth_mem[addr] = key;
         value_mem[addr] = r.intensity;
      end
      if (cnt != CNT_MAX) cnt++;
      count_mem[addr] = cnt;
      o.landed = 1'b1;
      o.target_col = 9'(tx);
      o.target_row = 9'(ty);
      o.became_front = front;
      o.pixel_value = value_mem.exists(addr) ? value_mem[addr] : PIX_EMPTY;
      o.hit_count = cnt;
      return o;
   endfunction

   // request driver: bursts with random gaps
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
         burst_left <= 1;
         gap_left <= 0;
      end else begin
         if (req_push && !req_full) begin
            predicted_pixels = {predicted_pixels, warp_pixel(req_data)};
            void'(point_queue.pop_front());
         end
         if (!(req_push && req_full)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_push <= 1'b0;
            end else if (point_queue.size() != 0) begin
               req_push <= 1'b1;
               req_data <= point_queue[0];
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, longint e, longint a);
      if (e != a) begin
         $error("%s mismatch: expected %0d actual %0d", name, e, a);
         err_count++;
      end
   endtask

   // result monitor with its own stall pattern
   int pop_pct;
   int pattern_cnt;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_pct <= 100;
         pattern_cnt <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (predicted_pixels.size() == 0) begin
               $error("unexpected transaction on result port");
               err_count++;
            end else begin
               e = predicted_pixels.pop_front();
               check_field("landed", e.landed, rsp_data.landed);
               check_field("target_col", e.target_col, rsp_data.target_col);
               check_field("target_row", e.target_row, rsp_data.target_row);
               check_field("became_front", e.became_front, rsp_data.became_front);
               check_field("pixel_value", e.pixel_value, rsp_data.pixel_value);
               check_field("hit_count", e.hit_count, rsp_data.hit_count);
               check_field("is_hole", e.is_hole, rsp_data.is_hole);
            end
         end
         pattern_cnt <= pattern_cnt + 1;
         if (pattern_cnt % 200 == 0) begin
            case ($urandom_range(0, 3))
               0: pop_pct <= 100;
               1: pop_pct <= 70;
               2: pop_pct <= 20;
               default: pop_pct <= 3;
            endcase
         end
         rsp_pop <= ($urandom_range(0, 99) < pop_pct);
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      case (idx)
         CSR_ROT0: rot_mirror[0] = val[53:0];
         CSR_ROT1: rot_mirror[1] = val[53:0];
         CSR_ROT2: rot_mirror[2] = val[53:0];
         CSR_TRANS: trans_mirror = val;
         CSR_K0: cam_mirror[0] = val[53:0];
         CSR_K1: cam_mirror[1] = val[53:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [53:0] row3(int a, int b, int c);
      return {18'(c), 18'(b), 18'(a)};
   endfunction

   function automatic req_type project_item(int x, int y, int z, int inten);
      req_type r;
      r = '0;
      r.action = ACT_PROJECT;
      r.point_x = 24'(x);
      r.point_y = 24'(y);
      r.point_z = 24'(z);
      r.intensity = 8'(inten);
      return r;
   endfunction

   function automatic req_type read_item(int col, int row);
      req_type r;
      r = '0;
      r.action = ACT_READ;
      r.read_col = 9'(col);
      r.read_row = 9'(row);
      return r;
   endfunction

   function automatic req_type noise_item();
      req_type r;
      r = req_type'($bits(req_type)'({$urandom, $urandom, $urandom, $urandom}));
      return r;
   endfunction

   // pixel near the image center with z from four levels one time in three, else random (forces depth ties)
   function automatic req_type aimed_item(int window);
      int z;
      z = ($urandom_range(0, 2) == 0) ? 4096 * $urandom_range(1, 4)
                                      : $urandom_range(1, 200000);
      return project_item(z * $urandom_range(0, 2 * window) / 64 - z * window / 64
                          + $urandom_range(0, 7),
                          z * $urandom_range(0, 2 * window) / 64 - z * window / 64,
                          z, $urandom_range(0, 255));
   endfunction

   // wait until the block has nothing in flight
   task automatic drain();
      while (point_queue.size() != 0 || req_push || predicted_pixels.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // main sequence
   initial begin
      int s;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      err_count = 0;
      rot_mirror[0] = ROT0_RST;
      rot_mirror[1] = ROT1_RST;
      rot_mirror[2] = ROT2_RST;
      trans_mirror = TRANS_RST;
      cam_mirror[0] = K0_RST;
      cam_mirror[1] = K1_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset config maps 4x/z and 1024y/z to the pixel
      add_item(read_item(5, 7));
      add_item(project_item(4096 * 5, 4096 * 7, 4096, 10));
      add_item(project_item(8192 * 5, 8192 * 7, 8192, 20));
      add_item(project_item(4096 * 5, 4096 * 7, 4096, 30));
      add_item(project_item(2048 * 5, 2048 * 7, 2048, 40));
      add_item(read_item(5, 7));
      add_item(project_item(10240, 0, 4096, 255));
      add_item(project_item(-2048, 0, 4096, 1));
      add_item(project_item(-1638, 0, 4096, 2));
      add_item(project_item(0, 0, 0, 3));
      add_item(project_item(0, 0, -4096, 4));
      add_item(project_item(0, 0, -8388608, 0));
      add_item(project_item(8388607, 8388607, 8388607, 255));
      add_item(project_item(-8388608, -8388608, 8388607, 0));
      add_item(project_item(4096 * 600, 0, 4096, 5));
      add_item(project_item(0, 4096 * 511, 4096, 6));
      add_item(project_item(4096 * 511, 4096 * 511, 4096, 7));
      add_item(read_item(511, 511));
      add_item(read_item(0, 0));
      add_item(read_item(3, 0));
      drain();

      // centered camera, diagonal reset rotation, small translation
      csr_write(CSR_K0, {6'd0, row3(8192, 0, 8192)});
      csr_write(CSR_K1, {6'd0, row3(0, 8192, 8192)});
      csr_write(CSR_TRANS, {20'($urandom_range(0, 200)), 20'($urandom_range(0, 100) - 50),
                            20'($urandom_range(0, 100) - 50)});
      @(negedge clock);
      // hammer the pixels near the center, then let every result come back
      for (int i = 0; i < 262; i++) begin
         s = $urandom_range(4096, 60000);
         add_item(project_item(0, 0, s, $urandom_range(0, 255)));
      end
      drain();
      for (int i = 0; i < 140; i++) begin
         s = $urandom_range(0, 9);
         if (s < 6) add_item(aimed_item(8));
         else if (s < 8) add_item(read_item(256 + $urandom_range(0, 40) - 20,
                                            256 + $urandom_range(0, 40) - 20));
         else add_item(noise_item());
      end
      drain();

      // rotation near identity
      for (int i = 0; i < 3; i++)
         csr_write(CSR_IDX_W'(CSR_ROT0 + i),
                   {6'd0, row3(i == 0 ? 65536 + $urandom_range(0, 400) - 200
                                      : $urandom_range(0, 400) - 200,
                               i == 1 ? 65536 + $urandom_range(0, 400) - 200
                                      : $urandom_range(0, 400) - 200,
                               i == 2 ? 65536 + $urandom_range(0, 400) - 200
                                      : $urandom_range(0, 400) - 200)});
      @(negedge clock);
      for (int i = 0; i < 110; i++) begin
         s = $urandom_range(0, 9);
         if (s < 6) add_item(aimed_item(30));
         else if (s < 8) add_item(read_item($urandom_range(0, 511),
                                            $urandom_range(0, 511)));
         else add_item(noise_item());
      end
      drain();

      // extreme register settings: all ones, max positive, min negative
      for (int ph = 0; ph < 3; ph++) begin
         for (int i = 0; i < 6; i++) begin
            if (i == 3)
               csr_write(CSR_TRANS, ph == 0 ? {60{1'b1}} : ph == 1 ? {3{20'h7FFFF}}
                                                              : {3{20'h80000}});
            else
               csr_write(CSR_IDX_W'(CSR_ROT0 + i),
                         ph == 0 ? {CSR_W{1'b1}}
                                 : ph == 1 ? {6'd0, {3{18'h1FFFF}}}
                                           : {6'd0, {3{18'h20000}}});
         end
         @(negedge clock);
         for (int i = 0; i < 15; i++) add_item(noise_item());
         drain();
      end

      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit: clearing pass plus slow handshakes, several times over
   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/fwz_pkg.sv
design/fwz_front.sv
design/fwz_cmd_fifo.sv
design/fwz_back.sv
design/forward_warp_zbuffer_core.sv
tb/tb_top.sv
